// File: design/gbp_pkg.sv
// Shared types and constants for the gshare branch predictor.
package gbp_pkg;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_t;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN   = 2'd0;
  localparam ctr_t CTR_TAKEN = 2'd2;
  localparam ctr_t CTR_MAX   = 2'd3;

  localparam logic [31:0] PC_STEP = 32'd4;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

endpackage

// File: design/gbp_if.sv
// Request and response channel interfaces for the gshare branch predictor.
interface gbp_in_if import gbp_pkg::*; ();
  logic        valid;
  logic        ready;
  op_t         op;
  logic [31:0] pc;
  logic [31:0] actual_target;
  logic        taken;

  modport source (output valid, op, pc, actual_target, taken, input ready);
  modport sink   (input valid, op, pc, actual_target, taken, output ready);
endinterface

interface gbp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] predicted_next_pc;
  logic        predicted_taken;

  modport source (output valid, predicted_next_pc, predicted_taken, input ready);
  modport sink   (input valid, predicted_next_pc, predicted_taken, output ready);
endinterface

// File: design/gbp_ram.sv
// Generic single-port synchronous RAM with registered read data.
module gbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: design/gshare_branch_predictor.sv
// Gshare branch predictor top level: counter table, target buffer and history.
// A predict result passes the registered memory read and then the output
//   register, and is held back while an earlier result stalls.
// A new request is taken only after the last leaves lookup; each is a read, and
//   an update adds a write-back of the counter (and of the target buffer if taken).
// Reset: synchronous, active low. A clearing sweep over every counter and
//   target-buffer entry zeroes counters and valid bits
//   while in_req.ready stays low.
module gshare_branch_predictor import gbp_pkg::*; #(
  parameter int TARGET_ENTRIES = 64,
  parameter int HISTORY_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  gbp_in_if.sink      in_req,
  gbp_out_if.source   out_rsp
);

  // Geometry
  localparam int IB        = $clog2(TARGET_ENTRIES);
  localparam int TAG_W     = 32 - 2 - IB;
  localparam int BTB_W     = 1 + TAG_W + 32;
  localparam int CNT_DEPTH = 1 << HISTORY_BITS;
  localparam int CW        = (HISTORY_BITS > IB) ? HISTORY_BITS : IB;
  localparam int CLR_LAST  =
    ((CNT_DEPTH > TARGET_ENTRIES) ? CNT_DEPTH : TARGET_ENTRIES) - 1;

  localparam logic [IB-1:0] BTB_MASK = IB'(TARGET_ENTRIES - 1);

  // Control and request registers
  state_t                  state_r, state_nxt;
  logic [CW-1:0]           clr_r, clr_nxt;
  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [31:0]             out_pc_r, out_pc_nxt;
  logic                    out_taken_r, out_taken_nxt;

  op_t                     req_op_r;
  logic [31:0]             req_pc_r;
  logic [31:0]             req_tgt_r;
  logic                    req_taken_r;
  logic [HISTORY_BITS-1:0] req_ci_r;
  logic [IB-1:0]           req_bi_r;

  // Memory ports
  logic [HISTORY_BITS-1:0] ctr_addr;
  logic                    ctr_we, ctr_re;
  ctr_t                    ctr_wdata, ctr_rdata;
  logic [IB-1:0]           btb_addr;
  logic                    btb_we, btb_re;
  logic [BTB_W-1:0]        btb_wdata, btb_rdata;

  // Lookup decode
  logic                    in_fire;
  logic [HISTORY_BITS-1:0] in_ci;
  logic [IB-1:0]           in_bi;
  logic                    btb_valid;
  logic [TAG_W-1:0]        btb_tag;
  logic [31:0]             btb_target;
  logic                    pred_taken;
  logic                    btb_hit;
  logic                    out_free;
  ctr_t                    ctr_upd;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  // gshare index: word address xor global history; buffer index masked
  assign in_ci = in_req.pc[HISTORY_BITS+1:2] ^ hist_r;
  assign in_bi = in_req.pc[IB+1:2] & BTB_MASK;

  assign {btb_valid, btb_tag, btb_target} = btb_rdata;

  assign pred_taken = (ctr_rdata >= CTR_TAKEN);
  assign btb_hit    = btb_valid && (btb_tag == req_pc_r[31:IB+2]);
  assign out_free   = !out_valid_r || out_rsp.ready;

  // Saturating two-bit counter step toward the outcome
  always_comb begin
    if (req_taken_r) begin
      ctr_upd = (ctr_rdata == CTR_MAX) ? ctr_rdata : ctr_rdata + 2'd1;
    end else begin
      ctr_upd = (ctr_rdata == CTR_MIN) ? ctr_rdata : ctr_rdata - 2'd1;
    end
  end

  // Memory port steering: sweep while clearing, read on accept, write back on update in lookup
  always_comb begin
    ctr_addr  = req_ci_r;
    ctr_we    = 1'b0;
    ctr_re    = 1'b0;
    ctr_wdata = ctr_upd;
    btb_addr  = req_bi_r;
    btb_we    = 1'b0;
    btb_re    = 1'b0;
    btb_wdata = {1'b1, req_pc_r[31:IB+2], req_tgt_r};
    case (state_r)
      ST_CLEAR: begin
        ctr_addr  = clr_r[HISTORY_BITS-1:0];
        ctr_we    = 1'b1;
        ctr_wdata = CTR_MIN;
        btb_addr  = clr_r[IB-1:0];
        btb_we    = ({1'b0, clr_r} < (CW+1)'(TARGET_ENTRIES));
        btb_wdata = '0;
      end
      ST_IDLE: begin
        ctr_addr = in_ci;
        ctr_re   = in_fire;
        btb_addr = in_bi;
        btb_re   = in_fire;
      end
      ST_LOOK: begin
        ctr_we = (req_op_r == OP_UPDATE);
        btb_we = (req_op_r == OP_UPDATE) && req_taken_r;
      end
      default: begin
        ctr_we = 1'b0;
      end
    endcase
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    hist_nxt      = hist_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_pc_nxt    = out_pc_r;
    out_taken_nxt = out_taken_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(CLR_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (req_op_r == OP_UPDATE) begin
          hist_nxt  = HISTORY_BITS'({hist_r, req_taken_r});
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          // read data holds while the output is stalled
          out_valid_nxt = 1'b1;
          out_taken_nxt = pred_taken;
          out_pc_nxt    = (pred_taken && btb_hit) ? btb_target : req_pc_r + PC_STEP;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_pc_r    <= out_pc_nxt;
    out_taken_r <= out_taken_nxt;
    if (in_fire) begin
      req_op_r    <= in_req.op;
      req_pc_r    <= in_req.pc;
      req_tgt_r   <= in_req.actual_target;
      req_taken_r <= in_req.taken;
      req_ci_r    <= in_ci;
      req_bi_r    <= in_bi;
    end
  end

  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.predicted_next_pc = out_pc_r;
  assign out_rsp.predicted_taken   = out_taken_r;

  // Direction counter table
  gbp_ram #(
    .WIDTH ($bits(ctr_t)),
    .DEPTH (CNT_DEPTH)
  ) u_ctr_ram (
    .clk   (clk),
    .addr  (ctr_addr),
    .we    (ctr_we),
    .wdata (ctr_wdata),
    .re    (ctr_re),
    .rdata (ctr_rdata)
  );

  // Target buffer: valid, tag, target
  gbp_ram #(
    .WIDTH (BTB_W),
    .DEPTH (TARGET_ENTRIES)
  ) u_btb_ram (
    .clk   (clk),
    .addr  (btb_addr),
    .we    (btb_we),
    .wdata (btb_wdata),
    .re    (btb_re),
    .rdata (btb_rdata)
  );

endmodule

// File: design/gbp_checker.sv
// Port-level assertions for the gshare branch predictor, bound to the top level.
module gbp_checker import gbp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input op_t         in_op,
  input logic [31:0] in_pc,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_next_pc,
  input logic        out_taken
);

  // Stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc) && $stable(out_taken))
    else $error("stalled response changed");

  // Update requests produce no response
  a_upd_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_UPDATE) && !out_valid |=> !out_valid)
    else $error("update produced a response");

  // Predict into an empty output answers once the memory read and output register are through
  a_pred_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_PREDICT) && !out_valid |=> ##1 out_valid)
    else $error("predict response late");

  // Not-taken prediction falls through to pc + 4
  a_fallthru: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && !out_taken |-> out_next_pc == 32'($past(in_pc, 2) + PC_STEP))
    else $error("not-taken prediction is not pc + 4");

endmodule

bind gshare_branch_predictor gbp_checker u_gbp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .in_op       (in_req.op),
  .in_pc       (in_req.pc),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_next_pc (out_rsp.predicted_next_pc),
  .out_taken   (out_rsp.predicted_taken)
);

// File: tb/sv/gbp_checker.sv
// Scoreboard for the gshare predictor: shadow tables, expected fetch queue and compare.
`timescale 1ns / 100ps
module gbp_scoreboard import gbp_pkg::*; #(
  parameter int TARGET_ENTRIES = 64,
  parameter int HISTORY_BITS   = 8
) (
  input  logic clk,
  input  logic rst_n,
  gbp_in_if    in_ch,
  gbp_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  localparam int CTR_DEPTH = 1 << HISTORY_BITS;
  localparam int IDX_W     = $clog2(TARGET_ENTRIES);
  localparam int TAG_W     = 32 - IDX_W - 2;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        taken;
  } fetch_guess_t;

  // shadow copy of the predictor state
  ctr_t                    dir_ctr   [CTR_DEPTH];
  logic [HISTORY_BITS-1:0] ghist;
  logic                    btb_valid [TARGET_ENTRIES];
  logic [TAG_W-1:0]        btb_tag   [TARGET_ENTRIES];
  logic [31:0]             btb_tgt   [TARGET_ENTRIES];

  fetch_guess_t fetch_queue [$];
  int           errors = 0;

  function automatic int ctr_slot(logic [31:0] pc);
    return int'(pc[HISTORY_BITS+1:2] ^ ghist);
  endfunction

  // mask, not modulo: matches the block for non-power-of-two sizes too
  function automatic int btb_slot(logic [31:0] pc);
    return int'((pc >> 2) & 32'(TARGET_ENTRIES - 1));
  endfunction

  function automatic logic [TAG_W-1:0] pc_tag(logic [31:0] pc);
    return TAG_W'(pc >> (IDX_W + 2));
  endfunction

  function automatic fetch_guess_t guess_fetch(logic [31:0] pc);
    fetch_guess_t g;
    int           slot;
    slot      = btb_slot(pc);
    g.taken   = dir_ctr[ctr_slot(pc)] >= CTR_TAKEN;
    g.next_pc = pc + PC_STEP;
    if (g.taken && btb_valid[slot] && btb_tag[slot] == pc_tag(pc))
      g.next_pc = btb_tgt[slot];
    return g;
  endfunction

  task automatic resolve_branch(logic [31:0] pc, logic [31:0] tgt, logic tk);
    int ci;
    int slot;
    ci   = ctr_slot(pc);
    slot = btb_slot(pc);
    if (tk) begin
      if (dir_ctr[ci] != CTR_MAX) dir_ctr[ci] = dir_ctr[ci] + 2'd1;
      btb_valid[slot] = 1'b1;
      btb_tag[slot]   = pc_tag(pc);
      btb_tgt[slot]   = tgt;
    end else begin
      if (dir_ctr[ci] != CTR_MIN) dir_ctr[ci] = dir_ctr[ci] - 2'd1;
    end
    ghist = HISTORY_BITS'({ghist, tk});
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    fetch_guess_t want;
    if (!rst_n) begin
      for (int i = 0; i < CTR_DEPTH; i++) dir_ctr[i] = CTR_MIN;
      for (int i = 0; i < TARGET_ENTRIES; i++) btb_valid[i] = 1'b0;
      ghist = '0;
      fetch_queue.delete();
    end else begin
      // results first: a request taken at this edge cannot answer at this edge
      if (out_ch.valid && out_ch.ready) begin
        if (fetch_queue.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, next_pc %h taken %b",
                                    out_ch.predicted_next_pc, out_ch.predicted_taken));
        end else begin
          want = fetch_queue.pop_front();
          if (out_ch.predicted_next_pc !== want.next_pc)
            report_mismatch($sformatf("predicted_next_pc got %h expected %h",
                                      out_ch.predicted_next_pc, want.next_pc));
          if (out_ch.predicted_taken !== want.taken)
            report_mismatch($sformatf("predicted_taken got %b expected %b",
                                      out_ch.predicted_taken, want.taken));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_PREDICT)
          fetch_queue.push_back(guess_fetch(in_ch.pc));
        else
          resolve_branch(in_ch.pc, in_ch.actual_target, in_ch.taken);
      end
    end
    fail_count <= errors;
    pending    <= fetch_queue.size();
  end

endmodule

// File: tb/sv/tb_gshare_branch_predictor.sv
// Testbench top for the gshare branch predictor: clock, reset, request stimulus, verdict.
`timescale 1ns / 100ps
module tb_gshare_branch_predictor import gbp_pkg::*;;

  localparam int TGT_ENTRIES = 64;
  localparam int HIST_BITS   = 8;

  // Worst case: clearing sweep, then ~1450 requests plus sender gaps and
  // receiver stalls of the slowest phase. Several times over.
  localparam int CYCLE_LIMIT = 400000;

  // Number of random requests per idling phase (three phases, ~1450 total).
  localparam int PHASE_REQS  = 477;

  // Directed training: a fixed upper pc part and a counter slot to hammer.
  localparam logic [21:0] TRAIN_HI   = 22'h048D1;
  localparam logic [7:0]  TRAIN_SLOT = 8'h5A;

  localparam int POOL_N = 8;

  logic clk = 1'b0;
  logic rst_n;

  gbp_in_if  in_ch ();
  gbp_out_if out_ch ();

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent_count  = 0;

  // Idle rates in percent; the sender's gaps live in send_req, the
  // receiver's stalls in the ready process below.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Pool of "hot" branches for the random part: repeated pcs with a fixed
  // bias so the counters actually train and the target buffer gets hits.
  logic [31:0] branch_pc   [POOL_N];
  logic [31:0] branch_tgt  [POOL_N];
  int          branch_bias [POOL_N];

  gshare_branch_predictor #(
    .TARGET_ENTRIES (TGT_ENTRIES),
    .HISTORY_BITS   (HIST_BITS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_rsp (out_ch)
  );

  gbp_scoreboard #(
    .TARGET_ENTRIES (TGT_ENTRIES),
    .HISTORY_BITS   (HIST_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver side: random backpressure on the result channel.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hang or lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] pc_at(logic [21:0] hi, logic [7:0] slot);
    return {hi, slot, 2'b00};
  endfunction

  // Present one request and hold it until the block takes it. Entered right
  // after a rising edge; returns right after the accepting edge.
  task automatic send_req(op_t op, logic [31:0] pc, logic [31:0] tgt, logic tk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.pc            <= pc;
    in_ch.actual_target <= tgt;
    in_ch.taken         <= tk;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  task automatic run_directed();
    logic [7:0]  h;
    logic [31:0] hit_pc;
    h      = '0;
    hit_pc = pc_at(TRAIN_HI, TRAIN_SLOT ^ 8'hFF);

    // cold tables: everything not taken, pc + 4, including the wrap at the top
    send_req(OP_PREDICT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_req(OP_PREDICT, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1);
    send_req(OP_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);

    // not-taken update on a zero counter: must stay at zero, history stays 0
    send_req(OP_UPDATE, 32'h0000_0ABC, 32'h0000_0000, 1'b0);

    // Taken updates chosen so pc XOR history keeps landing on TRAIN_SLOT:
    // the counter climbs and saturates, history fills with ones.
    for (int k = 0; k < 8; k++) begin
      send_req(OP_UPDATE, pc_at(TRAIN_HI, TRAIN_SLOT ^ h), 32'h0040_0000 + k, 1'b1);
      h = {h[6:0], 1'b1};
      // counter is high but this pc's buffer entry was never written
      if (k == 2) send_req(OP_PREDICT, pc_at(TRAIN_HI, TRAIN_SLOT ^ h), 32'h0, 1'b0);
    end

    // history is all ones now; hit_pc maps to the saturated counter
    send_req(OP_UPDATE, hit_pc, 32'h0000_0000, 1'b1);
    send_req(OP_PREDICT, hit_pc, 32'h0, 1'b0);
    send_req(OP_UPDATE, hit_pc, 32'hFFFF_FFFF, 1'b1);
    send_req(OP_PREDICT, hit_pc, 32'h0, 1'b0);
    // same buffer slot and counter, different tag: taken but pc + 4
    send_req(OP_PREDICT, hit_pc ^ 32'h8000_0000, 32'h0, 1'b0);

    // step the counter down from the top, then read it back as weakly taken
    send_req(OP_UPDATE, hit_pc, 32'h1234_5678, 1'b0);
    send_req(OP_PREDICT, pc_at(TRAIN_HI, TRAIN_SLOT ^ 8'hFE), 32'h0, 1'b0);
  endtask

  task automatic refresh_pool();
    for (int j = 0; j < POOL_N; j++) begin
      // upper half aliases the lower half: same buffer slot, other tag
      if (j < POOL_N / 2) branch_pc[j] = $urandom();
      else branch_pc[j] = {24'($urandom()), branch_pc[j - POOL_N / 2][7:0]};
      branch_tgt[j] = $urandom();
      case ($urandom_range(2))
        0:       branch_bias[j] = 5;
        1:       branch_bias[j] = 50;
        default: branch_bias[j] = 95;
      endcase
    end
  endtask

  task automatic run_random(int n_reqs);
    int          stop_at;
    int          pick;
    int          j;
    logic [31:0] tgt;
    stop_at = sent_count + n_reqs;
    refresh_pool();
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        // fetch, then usually resolve the same branch with its bias
        j = $urandom_range(POOL_N - 1);
        send_req(OP_PREDICT, branch_pc[j], $urandom(), 1'($urandom()));
        if ($urandom_range(99) < 85) begin
          tgt = ($urandom_range(9) == 0) ? $urandom() : branch_tgt[j];
          send_req(OP_UPDATE, branch_pc[j], tgt,
                   $urandom_range(99) < branch_bias[j]);
        end
      end else if (pick < 80) begin
        send_req(OP_PREDICT, $urandom(), $urandom(), 1'($urandom()));
      end else begin
        send_req(OP_UPDATE, $urandom(), $urandom(), 1'($urandom()));
      end
    end
  endtask

  initial begin
    // request inputs known from time zero; ready comes from the receiver process
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_PREDICT;
    in_ch.pc            <= '0;
    in_ch.actual_target <= '0;
    in_ch.taken         <= 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing sweep after reset is absorbed by the ready handshake

    // phase one: sender idles often, receiver stalls most of the time
    send_idle_pct = 36;
    recv_idle_pct = 72;
    run_directed();
    run_random(PHASE_REQS);

    // phase two: rates swapped
    send_idle_pct = 72;
    recv_idle_pct = 36;
    run_random(PHASE_REQS);

    // phase three: back to back, no stalls
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_REQS);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // keep the clock running to catch any stray result
    repeat (16) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
design/gbp_pkg.sv
design/gbp_if.sv
design/gbp_ram.sv
design/gshare_branch_predictor.sv
design/gbp_checker.sv
tb/sv/gbp_checker.sv
tb/sv/tb_gshare_branch_predictor.sv
